>>> rtl/ltd_pkg.sv
// Shared types, constants and codes of the location table decoder.
`default_nettype none

package ltd_pkg;

  // Entries decoded before the table is given up as not found.
  localparam int unsigned MaxEntries = 65536;
  localparam int unsigned EntryW     = $clog2(MaxEntries + 1);

  localparam int unsigned PosW    = 20;
  localparam int unsigned LineW   = 32;
  localparam int unsigned ColW    = 31;
  localparam int unsigned VarintW = 30;
  localparam int unsigned ChunkW  = 3;
  localparam int unsigned VarintMaxChunks = 5;

  // Entry kind codes with a meaning of their own.
  localparam logic [3:0] KindOneLine0 = 4'd10;
  localparam logic [3:0] KindNoCols   = 4'd13;
  localparam logic [3:0] KindLong     = 4'd14;
  localparam logic [3:0] KindNone     = 4'd15;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_VARINT,
    PH_COL_A,
    PH_COL_B
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOTFOUND  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FLD_LINE,
    FLD_END_LINE,
    FLD_COL_START,
    FLD_COL_END
  } field_e;

  typedef struct packed {
    phase_e                   phase;
    logic [3:0]               kind;
    logic [3:0]               span;
    logic [PosW-1:0]          code_pos;
    logic [LineW-1:0]         line;
    logic [31:0]              query;
    logic [VarintW-1:0]       vint;
    logic [ChunkW-1:0]        chunks;
    field_e                   field;
    logic [LineW-1:0]         loc_line_start;
    logic [LineW-1:0]         loc_line_end;
    logic [ColW-1:0]          loc_col_start;
    logic [ColW-1:0]          loc_col_end;
    logic [EntryW-1:0]        entries;
  } state_t;

  typedef struct packed {
    status_e          status;
    logic [LineW-1:0] line_start;
    logic [LineW-1:0] line_end;
    logic [ColW-1:0]  column_start;
    logic [ColW-1:0]  column_end;
  } result_t;

  localparam state_t StateRst = '{
    phase:          PH_IDLE,
    kind:           '0,
    span:           '0,
    code_pos:       '0,
    line:           '0,
    query:          '0,
    vint:           '0,
    chunks:         '0,
    field:          FLD_LINE,
    loc_line_start: '1,
    loc_line_end:   '1,
    loc_col_start:  '1,
    loc_col_end:    '1,
    entries:        '0
  };

endpackage

`default_nettype wire

>>> rtl/ltd_step.sv
// Next-state and result logic for one table byte of the location decoder.
`default_nettype none

module ltd_step (
  input  var ltd_pkg::state_t  state_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            start_i,
  input  wire logic            last_i,
  input  wire logic [31:0]     query_i,
  input  wire logic [31:0]     first_line_i,
  output ltd_pkg::state_t      state_o,
  output logic                 res_valid_o,
  output ltd_pkg::result_t     res_o
);

  ltd_pkg::state_t  base_s;
  ltd_pkg::state_t  nxt;
  logic             emit;
  ltd_pkg::status_e emit_status;
  logic             complete;
  logic             active;

  logic [3:0]                          hdr_kind;
  logic [ltd_pkg::VarintW-1:0]         chunk_sh;
  logic [ltd_pkg::VarintW-1:0]         vint_new;
  logic [ltd_pkg::ChunkW-1:0]          chunks_new;
  logic [ltd_pkg::LineW-1:0]           line_delta;
  logic [ltd_pkg::VarintW-2:0]         vmag;
  logic [6:0]                          short_col;
  logic [ltd_pkg::PosW:0]              pos_hi;
  logic [ltd_pkg::EntryW-1:0]          entries_new;
  logic                                hit;

  assign hdr_kind  = byte_i[6:3];
  assign short_col = {base_s.kind[3:0], byte_i[6:4]};

  // Place the new six-bit chunk at its position in the accumulator.
  always_comb begin
    case (base_s.chunks)
      3'd0:    chunk_sh = ltd_pkg::VarintW'(byte_i[5:0]);
      3'd1:    chunk_sh = ltd_pkg::VarintW'(byte_i[5:0]) << 6;
      3'd2:    chunk_sh = ltd_pkg::VarintW'(byte_i[5:0]) << 12;
      3'd3:    chunk_sh = ltd_pkg::VarintW'(byte_i[5:0]) << 18;
      3'd4:    chunk_sh = ltd_pkg::VarintW'(byte_i[5:0]) << 24;
      default: chunk_sh = '0;
    endcase
  end

  assign vint_new   = base_s.vint | chunk_sh;
  assign chunks_new = base_s.chunks + ltd_pkg::ChunkW'(1);
  assign vmag       = vint_new[ltd_pkg::VarintW-1:1];
  // Zig-zag style sign: an odd value is a negative step.
  assign line_delta = vint_new[0] ? (32'd0 - 32'(vmag)) : 32'(vmag);

  always_comb begin
    base_s = state_i;
    if (start_i) begin
      base_s       = ltd_pkg::StateRst;
      base_s.query = query_i;
      base_s.line  = first_line_i;
      base_s.phase = ltd_pkg::PH_HEADER;
    end

    nxt         = base_s;
    emit        = 1'b0;
    emit_status = ltd_pkg::ST_NOTFOUND;
    complete    = 1'b0;
    active      = 1'b1;
    pos_hi      = '0;
    entries_new = base_s.entries;
    hit         = 1'b0;

    case (base_s.phase)
      ltd_pkg::PH_HEADER: begin
        if (byte_i == 8'd0) begin
          emit        = 1'b1;
          emit_status = ltd_pkg::ST_NOTFOUND;
        end else begin
          nxt.kind   = hdr_kind;
          nxt.span   = {1'b0, byte_i[2:0]} + 4'd1;
          nxt.vint   = '0;
          nxt.chunks = '0;
          nxt.field  = ltd_pkg::FLD_LINE;
          if (hdr_kind == ltd_pkg::KindNone) begin
            nxt.loc_line_start = '1;
            nxt.loc_line_end   = '1;
            nxt.loc_col_start  = '1;
            nxt.loc_col_end    = '1;
            complete           = 1'b1;
          end else if (hdr_kind == ltd_pkg::KindLong || hdr_kind == ltd_pkg::KindNoCols) begin
            nxt.phase = ltd_pkg::PH_VARINT;
          end else begin
            if (hdr_kind >= ltd_pkg::KindOneLine0) begin
              nxt.line           = base_s.line + 32'(hdr_kind - ltd_pkg::KindOneLine0);
              nxt.loc_line_start = nxt.line;
              nxt.loc_line_end   = nxt.line;
            end
            nxt.phase = ltd_pkg::PH_COL_A;
          end
        end
      end
      ltd_pkg::PH_VARINT: begin
        nxt.vint   = vint_new;
        nxt.chunks = chunks_new;
        if (byte_i[6]) begin
          if (chunks_new >= ltd_pkg::ChunkW'(ltd_pkg::VarintMaxChunks)) begin
            emit        = 1'b1;
            emit_status = ltd_pkg::ST_MALFORMED;
          end
        end else begin
          nxt.vint   = '0;
          nxt.chunks = '0;
          case (base_s.field)
            ltd_pkg::FLD_LINE: begin
              nxt.line           = base_s.line + line_delta;
              nxt.loc_line_start = nxt.line;
              if (base_s.kind == ltd_pkg::KindNoCols) begin
                nxt.loc_line_end  = nxt.line;
                nxt.loc_col_start = '1;
                nxt.loc_col_end   = '1;
                complete          = 1'b1;
              end else begin
                nxt.field = ltd_pkg::FLD_END_LINE;
              end
            end
            ltd_pkg::FLD_END_LINE: begin
              nxt.loc_line_end = base_s.line + 32'(vint_new);
              nxt.field        = ltd_pkg::FLD_COL_START;
            end
            ltd_pkg::FLD_COL_START: begin
              nxt.loc_col_start = ltd_pkg::ColW'(vint_new) - ltd_pkg::ColW'(1);
              nxt.field         = ltd_pkg::FLD_COL_END;
            end
            default: begin
              nxt.loc_col_end = ltd_pkg::ColW'(vint_new) - ltd_pkg::ColW'(1);
              complete        = 1'b1;
            end
          endcase
        end
      end
      ltd_pkg::PH_COL_A: begin
        if (base_s.kind >= ltd_pkg::KindOneLine0) begin
          nxt.loc_col_start = ltd_pkg::ColW'(byte_i);
          nxt.phase         = ltd_pkg::PH_COL_B;
        end else if (byte_i[7]) begin
          emit        = 1'b1;
          emit_status = ltd_pkg::ST_MALFORMED;
        end else begin
          nxt.loc_line_start = base_s.line;
          nxt.loc_line_end   = base_s.line;
          nxt.loc_col_start  = ltd_pkg::ColW'(short_col);
          nxt.loc_col_end    = ltd_pkg::ColW'({1'b0, short_col} + {4'd0, byte_i[3:0]});
          complete           = 1'b1;
        end
      end
      ltd_pkg::PH_COL_B: begin
        nxt.loc_col_end = ltd_pkg::ColW'(byte_i);
        complete        = 1'b1;
      end
      default: begin
        // Finished: bytes outside a table are dropped.
        active = 1'b0;
      end
    endcase

    if (complete) begin
      pos_hi      = {1'b0, base_s.code_pos} + (ltd_pkg::PosW + 1)'(nxt.span);
      entries_new = base_s.entries + ltd_pkg::EntryW'(1);
      nxt.entries = entries_new;
      // A negative query is never covered.
      hit = !base_s.query[31]
         && (base_s.query >= 32'(base_s.code_pos))
         && (base_s.query < 32'(pos_hi));
      if (hit) begin
        emit        = 1'b1;
        emit_status = ltd_pkg::ST_FOUND;
      end else begin
        nxt.code_pos = pos_hi[ltd_pkg::PosW-1:0];
        nxt.phase    = ltd_pkg::PH_HEADER;
        if (last_i || (entries_new >= ltd_pkg::EntryW'(ltd_pkg::MaxEntries))) begin
          emit        = 1'b1;
          emit_status = ltd_pkg::ST_NOTFOUND;
        end
      end
    end else if (active && !emit && last_i) begin
      // The table ended inside an entry.
      emit        = 1'b1;
      emit_status = ltd_pkg::ST_MALFORMED;
    end

    if (emit) begin
      nxt.phase = ltd_pkg::PH_IDLE;
    end
  end

  always_comb begin
    res_o.status = emit_status;
    if (emit_status == ltd_pkg::ST_FOUND) begin
      res_o.line_start   = nxt.loc_line_start;
      res_o.line_end     = nxt.loc_line_end;
      res_o.column_start = nxt.loc_col_start;
      res_o.column_end   = nxt.loc_col_end;
    end else begin
      res_o.line_start   = '1;
      res_o.line_end     = '1;
      res_o.column_start = '1;
      res_o.column_end   = '1;
    end
  end

  assign state_o     = nxt;
  assign res_valid_o = emit;

endmodule

`default_nettype wire

>>> rtl/location_table_decoder.sv
// Top level of the byte-serial location table decoder.
`default_nettype none

// Channel   Dir  Fields (tdata/tuser from bit 0 upwards)
// s_axis    in   tdata: table_byte[7:0], query_offset[39:8], first_line[71:40]
//                tuser: start_of_table; tlast: last_byte
// m_axis    out  tdata: line_start[31:0], line_end[63:32], column_start[94:64],
//                column_end[125:95], zero padding [127:126]; tuser: status
//
// One table byte is taken per cycle unless a waiting result holds the input.
// Each request waits in the input register, then the decode logic updates the
// parse state and, when the table is decided, loads the result register. A
// waiting result only holds the input when the next byte would also produce a
// result. Reset is asynchronous and active low; it leaves the block finished,
// so bytes are ignored until one arrives with start_of_table set.

module location_table_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [71:0]  s_axis_tdata_i,  // table_byte, query_offset, first_line
  input  wire logic         s_axis_tuser_i,  // start_of_table
  input  wire logic         s_axis_tlast_i,  // last_byte

  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o,  // line_start, line_end, column_start,
                                             // column_end, zero padding
  output logic [1:0]        m_axis_tuser_o   // status
);

  // Input register: one request waiting for the decode logic.
  logic        in_valid_q;
  logic [71:0] in_data_q;
  logic        in_start_q;
  logic        in_last_q;

  // Parse state carried from byte to byte.
  ltd_pkg::state_t state_q;
  ltd_pkg::state_t state_d;

  // Result register.
  logic             out_valid_q;
  ltd_pkg::result_t out_res_q;

  logic             res_valid;
  ltd_pkg::result_t res;
  logic             advance;

  ltd_step u_step (
    .state_i      (state_q),
    .byte_i       (in_data_q[7:0]),
    .start_i      (in_start_q),
    .last_i       (in_last_q),
    .query_i      (in_data_q[39:8]),
    .first_line_i (in_data_q[71:40]),
    .state_o      (state_d),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // The held request moves on unless it makes a result that has nowhere to go.
  assign advance         = in_valid_q && (!res_valid || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i;
      in_last_q  <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ltd_pkg::StateRst;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {2'b00, out_res_q.column_end, out_res_q.column_start,
                            out_res_q.line_end, out_res_q.line_start};

  // A result that is not a hit carries no location at all.
  a_miss_no_location: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.status != ltd_pkg::ST_FOUND) |->
      (out_res_q.line_start == '1 && out_res_q.line_end == '1
       && out_res_q.column_start == '1 && out_res_q.column_end == '1))
    else $error("miss result carries a location");

  // Once a table is decided the parser waits for the next table start.
  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |=> (state_q.phase == ltd_pkg::PH_IDLE))
    else $error("parser not finished after a result");

  // Outside a table, only a table start can produce a result.
  a_no_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_start_q && state_q.phase == ltd_pkg::PH_IDLE) |-> !res_valid)
    else $error("result produced outside a table");

  // A held request is never dropped before the decode logic takes it.
  a_input_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q)))
    else $error("input register lost a request");

endmodule

`default_nettype wire
